### design/stl_pkg.sv
// package for the script token lexer: token kinds, error codes, command codes,
// lexer mode encoding, character constants and character classification
// no dependencies
package stl_pkg;

   localparam int STL_LINE_BITS   = 24;
   localparam int STL_OFFSET_BITS = 32;
   localparam int STL_LENGTH_BITS = 16;

   localparam int VALUE_BITS = 64;

   // command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // token kinds
   localparam logic [3:0] K_IDENT  = 4'd0;
   localparam logic [3:0] K_NUMBER = 4'd1;
   localparam logic [3:0] K_LBRACE = 4'd2;
   localparam logic [3:0] K_RBRACE = 4'd3;
   localparam logic [3:0] K_LPAREN = 4'd4;
   localparam logic [3:0] K_RPAREN = 4'd5;
   localparam logic [3:0] K_COLON  = 4'd6;
   localparam logic [3:0] K_SEMI   = 4'd7;
   localparam logic [3:0] K_ASSIGN = 4'd8;
   localparam logic [3:0] K_STAR   = 4'd9;
   localparam logic [3:0] K_PLUS   = 4'd10;
   localparam logic [3:0] K_MINUS  = 4'd11;
   localparam logic [3:0] K_SLASH  = 4'd12;
   localparam logic [3:0] K_SHL    = 4'd13;
   localparam logic [3:0] K_END    = 4'd14;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_NUMBER = 2'd1;
   localparam logic [1:0] ERR_BAD_CHAR   = 2'd2;

   // characters
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_DOLLAR = "$";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_LT     = "<";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_X_LO   = "x";
   localparam logic [7:0] CH_X_UP   = "X";

   typedef enum logic [11:0] {
      MODE_IDLE    = 12'b0000_0000_0001,
      MODE_IDENT   = 12'b0000_0000_0010,
      MODE_DEC     = 12'b0000_0000_0100,
      MODE_ZERO    = 12'b0000_0000_1000,
      MODE_ZX      = 12'b0000_0001_0000,
      MODE_HEX     = 12'b0000_0010_0000,
      MODE_OCT     = 12'b0000_0100_0000,
      MODE_LT      = 12'b0000_1000_0000,
      MODE_SLASH   = 12'b0001_0000_0000,
      MODE_COMMENT = 12'b0010_0000_0000,
      MODE_CSTAR   = 12'b0100_0000_0000,
      MODE_HALT    = 12'b1000_0000_0000
   } mode_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_octal(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_start(input logic [7:0] c);
      return is_alpha(c) || c == CH_UNDER || c == CH_DOLLAR || c == CH_DOT;
   endfunction

   function automatic logic is_cont(input logic [7:0] c);
      return is_start(c) || is_digit(c);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // letters a-f and A-F share their low three bits, value is that plus nine
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (is_digit(c)) begin
         v = c[3:0];
      end else begin
         v = 4'({1'b0, c[2:0]} + 4'd9);
      end
      return v;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      logic r;
      case (c)
         "{", "}", "(", ")", ":", ";", "=", "*", "+", "-": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         ":": k = K_COLON;
         ";": k = K_SEMI;
         "=": k = K_ASSIGN;
         "*": k = K_STAR;
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         default: k = K_IDENT;
      endcase
      return k;
   endfunction

endpackage

### design/script_token_lexer.sv
// script token lexer top level: source bytes and end markers in, tokens out
// through a four-entry result queue; depends on stl_pkg
// a transaction's results enter the queue in the cycle after it is accepted
// throughput: one transaction per cycle while two queue entries are free; up to two
//    results per transaction, a third one waits for the next transaction
// reset: synchronous, active high; line 1, column 1, offset 0, result queue empty
module script_token_lexer
   import stl_pkg::*;
#(
   parameter int LINE_BITS   = STL_LINE_BITS,
   parameter int OFFSET_BITS = STL_OFFSET_BITS,
   parameter int LENGTH_BITS = STL_LENGTH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [7:0]             req_source_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_token_kind,
   output logic [1:0]             rsp_error_code,
   output logic [OFFSET_BITS-1:0] rsp_token_offset,
   output logic [LINE_BITS-1:0]   rsp_token_line,
   output logic [LINE_BITS-1:0]   rsp_token_column,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic [VALUE_BITS-1:0]  rsp_number_value,
   output logic                   rsp_last_of_run
);

   typedef struct packed {
      logic [3:0]             kind;
      logic [1:0]             err;
      logic [OFFSET_BITS-1:0] off;
      logic [LINE_BITS-1:0]   line;
      logic [LINE_BITS-1:0]   col;
      logic [LENGTH_BITS-1:0] len;
      logic [VALUE_BITS-1:0]  val;
      logic                   last;
   } result_type;

   function automatic result_type make_result(
      input logic [3:0]             kind,
      input logic [1:0]             err,
      input logic [OFFSET_BITS-1:0] off,
      input logic [LINE_BITS-1:0]   line,
      input logic [LINE_BITS-1:0]   col,
      input logic [LENGTH_BITS-1:0] len,
      input logic [VALUE_BITS-1:0]  val
   );
      result_type r;
      r.kind = kind;
      r.err  = err;
      r.off  = off;
      r.line = line;
      r.col  = col;
      r.len  = len;
      r.val  = val;
      r.last = 1'b0;
      return r;
   endfunction

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);
   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

   // lexer state
   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   cur_line_ff, cur_line_in;
   logic [LINE_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [OFFSET_BITS-1:0] cur_off_ff, cur_off_in;
   logic [LINE_BITS-1:0]   tok_line_ff, tok_line_in;
   logic [LINE_BITS-1:0]   tok_col_ff, tok_col_in;
   logic [OFFSET_BITS-1:0] tok_off_ff, tok_off_in;
   logic [LENGTH_BITS-1:0] tok_len_ff, tok_len_in;
   logic [VALUE_BITS-1:0]  num_ff, num_in;
   logic                   ovf_ff, ovf_in;

   // result carried over to the next transaction
   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;

   // result queue
   result_type             q_ff [4];
   logic [1:0]             head_ff, head_in;
   logic [2:0]             count_ff, count_in;
   logic [1:0]             wr0, wr1;

   logic                   item_acc, is_byte, pop;
   logic [7:0]             c;

   logic                   nl;
   logic [LINE_BITS-1:0]   line_inc, col_inc, tok_col_inc;
   logic [LINE_BITS-1:0]   adv_line, adv_col;
   logic [OFFSET_BITS-1:0] adv_off, tok_off_inc;
   logic [LENGTH_BITS-1:0] tok_len_inc;

   logic [VALUE_BITS+3:0]  dec_wide;
   logic                   dec_ovf, oct_ovf, hex_ovf;
   logic [VALUE_BITS-1:0]  oct_val, hex_val_acc;

   logic                   a1_v, a2_v, b_v, do_b, b_halt;
   result_type             a1_r, a2_r, b_r, s0, s1;
   logic [1:0]             n_res;

   assign item_acc = req_valid && req_ready;
   assign pop      = rsp_valid && rsp_ready;
   assign is_byte  = (req_command == CMD_BYTE);
   assign c        = req_source_byte;

   // position arithmetic
   assign nl          = (c == CH_NL);
   assign line_inc    = (cur_line_ff == LINE_MAX) ? cur_line_ff : cur_line_ff + LINE_ONE;
   assign col_inc     = (cur_col_ff == LINE_MAX) ? cur_col_ff : cur_col_ff + LINE_ONE;
   assign tok_col_inc = (tok_col_ff == LINE_MAX) ? tok_col_ff : tok_col_ff + LINE_ONE;
   assign tok_len_inc = (tok_len_ff == LEN_MAX) ? tok_len_ff : tok_len_ff + LEN_ONE;
   assign adv_line    = nl ? line_inc : cur_line_ff;
   assign adv_col     = nl ? LINE_ONE : col_inc;
   assign adv_off     = cur_off_ff + OFFSET_BITS'(1);
   assign tok_off_inc = tok_off_ff + OFFSET_BITS'(1);

   // digit accumulation
   assign dec_wide    = ({4'b0, num_ff} << 3) + ({4'b0, num_ff} << 1)
                        + (VALUE_BITS + 4)'(c[3:0]);
   assign dec_ovf     = |dec_wide[VALUE_BITS+3:VALUE_BITS];
   assign oct_ovf     = |num_ff[VALUE_BITS-1:VALUE_BITS-3];
   assign oct_val     = {num_ff[VALUE_BITS-4:0], c[2:0]};
   assign hex_ovf     = |num_ff[VALUE_BITS-1:VALUE_BITS-4];
   assign hex_val_acc = {num_ff[VALUE_BITS-5:0], hex_val(c)};

   always_comb begin
      mode_in     = mode_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      cur_off_in  = cur_off_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_off_in  = tok_off_ff;
      tok_len_in  = tok_len_ff;
      num_in      = num_ff;
      ovf_in      = ovf_ff;
      a1_v        = 1'b0;
      a2_v        = 1'b0;
      b_v         = 1'b0;
      a1_r        = '0;
      a2_r        = '0;
      b_r         = '0;
      do_b        = 1'b0;
      b_halt      = 1'b0;

      if (item_acc) begin
         // continue or close the token in progress
         unique case (mode_ff)
            MODE_IDLE: begin
               do_b = 1'b1;
            end
            MODE_HALT: begin
               do_b   = 1'b1;
               b_halt = 1'b1;
            end
            MODE_IDENT: begin
               if (is_byte && is_cont(c)) begin
                  tok_len_in  = tok_len_inc;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else begin
                  a1_v = 1'b1;
                  a1_r = make_result(K_IDENT, ERR_NONE, tok_off_ff, tok_line_ff, tok_col_ff,
                                     tok_len_ff, '0);
                  do_b = 1'b1;
               end
            end
            MODE_DEC, MODE_ZERO, MODE_OCT, MODE_HEX: begin
               if (is_byte && mode_ff == MODE_DEC && is_digit(c)) begin
                  if (!ovf_ff) begin
                     if (dec_ovf) ovf_in = 1'b1;
                     else num_in = dec_wide[VALUE_BITS-1:0];
                  end
                  tok_len_in  = tok_len_inc;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else if (is_byte && mode_ff == MODE_ZERO
                            && (c == CH_X_LO || c == CH_X_UP)) begin
                  mode_in     = MODE_ZX;
                  tok_len_in  = tok_len_inc;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else if (is_byte && (mode_ff == MODE_ZERO || mode_ff == MODE_OCT)
                            && is_octal(c)) begin
                  mode_in = MODE_OCT;
                  if (!ovf_ff) begin
                     if (oct_ovf) ovf_in = 1'b1;
                     else num_in = oct_val;
                  end
                  tok_len_in  = tok_len_inc;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else if (is_byte && mode_ff == MODE_HEX && is_hex(c)) begin
                  if (!ovf_ff) begin
                     if (hex_ovf) ovf_in = 1'b1;
                     else num_in = hex_val_acc;
                  end
                  tok_len_in  = tok_len_inc;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else begin
                  a1_v = 1'b1;
                  do_b = 1'b1;
                  if (ovf_ff) begin
                     a1_r   = make_result(K_IDENT, ERR_BAD_NUMBER, tok_off_ff, tok_line_ff,
                                          tok_col_ff, '0, '0);
                     b_halt = 1'b1;
                  end else begin
                     a1_r = make_result(K_NUMBER, ERR_NONE, tok_off_ff, tok_line_ff,
                                        tok_col_ff, tok_len_ff, num_ff);
                  end
               end
            end
            MODE_ZX: begin
               if (is_byte && is_hex(c)) begin
                  mode_in     = MODE_HEX;
                  num_in      = VALUE_BITS'(hex_val(c));
                  tok_len_in  = tok_len_inc;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else begin
                  // bare 0x: number zero, then x starts an identifier
                  a1_v       = 1'b1;
                  a1_r       = make_result(K_NUMBER, ERR_NONE, tok_off_ff, tok_line_ff,
                                           tok_col_ff, LEN_ONE, '0);
                  tok_off_in = tok_off_inc;
                  tok_col_in = tok_col_inc;
                  if (is_byte && is_cont(c)) begin
                     mode_in     = MODE_IDENT;
                     tok_len_in  = LEN_TWO;
                     cur_line_in = adv_line;
                     cur_col_in  = adv_col;
                     cur_off_in  = adv_off;
                  end else begin
                     tok_len_in = LEN_ONE;
                     a2_v       = 1'b1;
                     a2_r       = make_result(K_IDENT, ERR_NONE, tok_off_inc, tok_line_ff,
                                              tok_col_inc, LEN_ONE, '0);
                     do_b       = 1'b1;
                  end
               end
            end
            MODE_LT: begin
               if (is_byte && c == CH_LT) begin
                  a1_v        = 1'b1;
                  a1_r        = make_result(K_SHL, ERR_NONE, tok_off_ff, tok_line_ff,
                                            tok_col_ff, LEN_TWO, '0);
                  tok_len_in  = LEN_TWO;
                  mode_in     = MODE_IDLE;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else begin
                  a1_v   = 1'b1;
                  a1_r   = make_result(K_IDENT, ERR_BAD_CHAR, tok_off_ff, tok_line_ff,
                                       tok_col_ff, '0, '0);
                  do_b   = 1'b1;
                  b_halt = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (is_byte && c == CH_STAR) begin
                  mode_in     = MODE_COMMENT;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else begin
                  tok_len_in = LEN_ONE;
                  a1_v       = 1'b1;
                  a1_r       = make_result(K_SLASH, ERR_NONE, tok_off_ff, tok_line_ff,
                                           tok_col_ff, LEN_ONE, '0);
                  do_b       = 1'b1;
               end
            end
            MODE_COMMENT, MODE_CSTAR: begin
               if (!is_byte) begin
                  do_b = 1'b1;
               end else begin
                  if (mode_ff == MODE_CSTAR && c == CH_SLASH) mode_in = MODE_IDLE;
                  else if (c == CH_STAR) mode_in = MODE_CSTAR;
                  else mode_in = MODE_COMMENT;
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         // the transaction seen between tokens, or while halted
         if (do_b) begin
            mode_in = b_halt ? MODE_HALT : MODE_IDLE;
            if (!is_byte) begin
               b_v         = 1'b1;
               b_r         = make_result(K_END, ERR_NONE, cur_off_ff, cur_line_ff, cur_col_ff,
                                         '0, '0);
               mode_in     = MODE_IDLE;
               cur_line_in = LINE_ONE;
               cur_col_in  = LINE_ONE;
               cur_off_in  = '0;
               tok_line_in = '0;
               tok_col_in  = '0;
               tok_off_in  = '0;
               tok_len_in  = '0;
               num_in      = '0;
               ovf_in      = 1'b0;
            end else if (!b_halt) begin
               if (is_space(c)) begin
                  cur_line_in = adv_line;
                  cur_col_in  = adv_col;
                  cur_off_in  = adv_off;
               end else begin
                  tok_line_in = cur_line_ff;
                  tok_col_in  = cur_col_ff;
                  tok_off_in  = cur_off_ff;
                  tok_len_in  = LEN_ONE;
                  if (is_start(c) || is_digit(c) || c == CH_SLASH || c == CH_LT
                      || is_punct(c)) begin
                     cur_line_in = adv_line;
                     cur_col_in  = adv_col;
                     cur_off_in  = adv_off;
                  end
                  if (is_start(c)) begin
                     mode_in = MODE_IDENT;
                  end else if (is_digit(c)) begin
                     num_in  = VALUE_BITS'(c[3:0]);
                     ovf_in  = 1'b0;
                     mode_in = (c[3:0] == 4'd0) ? MODE_ZERO : MODE_DEC;
                  end else if (c == CH_SLASH) begin
                     mode_in = MODE_SLASH;
                  end else if (c == CH_LT) begin
                     mode_in = MODE_LT;
                  end else if (is_punct(c)) begin
                     b_v = 1'b1;
                     b_r = make_result(punct_kind(c), ERR_NONE, cur_off_ff, cur_line_ff,
                                       cur_col_ff, LEN_ONE, '0);
                  end else begin
                     b_v     = 1'b1;
                     b_r     = make_result(K_IDENT, ERR_BAD_CHAR, cur_off_ff, cur_line_ff,
                                           cur_col_ff, '0, '0);
                     mode_in = MODE_HALT;
                  end
               end
            end
         end
      end
   end

   // order the results of this transaction, a third one waits for the next
   always_comb begin
      s0            = b_r;
      s1            = b_r;
      n_res         = 2'd0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (item_acc) begin
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            s0    = pend_ff;
            n_res = b_v ? 2'd2 : 2'd1;
         end else if (a2_v) begin
            s0            = a1_r;
            s1            = a2_r;
            n_res         = 2'd2;
            pend_valid_in = b_v;
            pend_in       = b_r;
         end else if (a1_v) begin
            s0    = a1_r;
            n_res = b_v ? 2'd2 : 2'd1;
         end else begin
            n_res = b_v ? 2'd1 : 2'd0;
         end
      end
      s0.last = (n_res == 2'd1);
      s1.last = 1'b1;
   end

   assign wr0      = head_ff + count_ff[1:0];
   assign wr1      = wr0 + 2'd1;
   assign head_in  = pop ? head_ff + 2'd1 : head_ff;
   assign count_in = count_ff + {1'b0, n_res} - {2'b0, pop};

   assign req_ready = (count_ff < 3'd3);
   assign rsp_valid = (count_ff != 3'd0);

   assign rsp_token_kind   = q_ff[head_ff].kind;
   assign rsp_error_code   = q_ff[head_ff].err;
   assign rsp_token_offset = q_ff[head_ff].off;
   assign rsp_token_line   = q_ff[head_ff].line;
   assign rsp_token_column = q_ff[head_ff].col;
   assign rsp_token_length = q_ff[head_ff].len;
   assign rsp_number_value = q_ff[head_ff].val;
   assign rsp_last_of_run  = q_ff[head_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         cur_line_ff   <= LINE_ONE;
         cur_col_ff    <= LINE_ONE;
         cur_off_ff    <= '0;
         tok_line_ff   <= '0;
         tok_col_ff    <= '0;
         tok_off_ff    <= '0;
         tok_len_ff    <= '0;
         num_ff        <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         head_ff       <= '0;
         count_ff      <= '0;
      end else begin
         mode_ff       <= mode_in;
         cur_line_ff   <= cur_line_in;
         cur_col_ff    <= cur_col_in;
         cur_off_ff    <= cur_off_in;
         tok_line_ff   <= tok_line_in;
         tok_col_ff    <= tok_col_in;
         tok_off_ff    <= tok_off_in;
         tok_len_ff    <= tok_len_in;
         num_ff        <= num_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (n_res != 2'd0) begin
         q_ff[wr0] <= s0;
      end
      if (n_res == 2'd2) begin
         q_ff[wr1] <= s1;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overfilled");

   a_mode_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(mode_ff))
      else $error("lexer mode not one-hot");

   a_pend_mode: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (mode_ff == MODE_IDLE || mode_ff == MODE_HALT))
      else $error("carried result with a token in progress");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (item_acc && req_command == CMD_END) |=>
         (mode_ff == MODE_IDLE && cur_off_ff == '0 && cur_line_ff == LINE_ONE))
      else $error("end marker did not restart the lexer");

endmodule
